// File: design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/efe_pkg.sv
package efe_pkg;

    localparam int MAX_FIELD_BYTES_DEF = 8;

    localparam logic [7:0] CR_BYTE          = 8'h0D;
    localparam logic [7:0] ESCAPE_RESET     = 8'd27;
    localparam logic [7:0] CAPACITY_RESET   = 8'd255;
    localparam logic [7:0] START_FILL_RESET = 8'd0;

    // Request commands
    localparam logic [1:0] CMD_FIELD  = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef logic [1:0] t_cfg_index;

    // Register indexes
    localparam t_cfg_index REG_ESCAPE     = 2'd0;
    localparam t_cfg_index REG_CAPACITY   = 2'd1;
    localparam t_cfg_index REG_START_FILL = 2'd2;

    typedef enum logic [2:0] {
        SEL_NULL,
        SEL_BYTE,
        SEL_ESC,
        SEL_XOR,
        SEL_RAW,
        SEL_CR
    } t_emit_sel;

    typedef enum logic [1:0] {
        FILL_HOLD,
        FILL_INC1,
        FILL_INC2,
        FILL_RELOAD
    } t_fill_op;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_emit_sel emit_sel;
        t_fill_op  fill_op;
        logic      shift;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       fits_esc;
        logic       fits_plain;
        logic       is_esc;
        logic       last_byte;
        logic       out_free;
    } t_dp_status;

endpackage

// File: design/efe_datapath.sv
module efe_datapath #(
    parameter int MAX_FIELD_BYTES = efe_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  efe_pkg::t_cfg_index  i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic [1:0]           i_command,
    input  logic [63:0]          i_value,
    input  logic [1:0]           i_field_bytes_code,
    input  logic                 i_out_stall,
    input  efe_pkg::t_dp_cmd     i_cmd,
    output efe_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_overflow,
    output logic                 o_last
);
    import efe_pkg::*;

    localparam int VW = 8 * MAX_FIELD_BYTES;
    localparam int CW = $clog2(MAX_FIELD_BYTES + 1);
    localparam int SW = $clog2(2 * MAX_FIELD_BYTES);

    logic [7:0]    r_escape;
    logic [7:0]    r_cap;
    logic [7:0]    r_start;
    logic [7:0]    r_fill;
    logic [7:0]    n_fill;
    logic [1:0]    r_cmd;
    logic [VW-1:0] r_val;
    logic [CW-1:0] r_left;
    logic          r_ovf;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_bv;
    logic          r_out_ovf;
    logic          r_out_last;

    logic [3:0]    len_pow;
    logic [CW-1:0] len_cap;
    logic [SW-1:0] lead_width;
    logic [9:0]    field_chk;
    logic          ovf_in;
    logic [7:0]    cur_byte;
    logic          is_esc;
    logic [8:0]    fill_step;
    logic          next_fits;
    logic          out_free;
    logic [7:0]    emit_byte;
    logic          emit_last;

    // Field length and the width of all bytes ahead of the final one.
    // Drops are monotonic, so the item overflows iff its final byte cannot fit.
    always_comb begin
        len_pow = 4'd1 << i_field_bytes_code;
        if (len_pow > 4'(MAX_FIELD_BYTES)) begin
            len_cap = CW'(MAX_FIELD_BYTES);
        end else begin
            len_cap = CW'(len_pow);
        end
        lead_width = '0;
        for (int j = 0; j < MAX_FIELD_BYTES; j++) begin
            if ((j + 1) < int'(len_cap)) begin
                if (i_value[8*j +: 8] == CR_BYTE || i_value[8*j +: 8] == r_escape) begin
                    lead_width = lead_width + SW'(2);
                end else begin
                    lead_width = lead_width + SW'(1);
                end
            end
        end
        field_chk = 10'(r_fill) + 10'(lead_width) + 10'd2;
        if (i_command == CMD_FIELD) begin
            ovf_in = (field_chk >= 10'(r_cap));
        end else begin
            ovf_in = (r_fill >= r_cap);
        end
    end

    assign cur_byte  = r_val[7:0];
    assign is_esc    = (cur_byte == CR_BYTE) || (cur_byte == r_escape);
    assign fill_step = 9'(r_fill) + (is_esc ? 9'd2 : 9'd1);
    assign next_fits = (10'(fill_step) + 10'd2) < 10'(r_cap);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_status.cmd        = r_cmd;
    assign o_status.fits_esc   = (9'(r_fill) + 9'd2) < 9'(r_cap);
    assign o_status.fits_plain = r_fill < r_cap;
    assign o_status.is_esc     = is_esc;
    assign o_status.last_byte  = (r_left == CW'(1)) || !next_fits;
    assign o_status.out_free   = out_free;

    always_comb begin
        unique case (i_cmd.fill_op)
            FILL_HOLD:   n_fill = r_fill;
            FILL_INC1:   n_fill = r_fill + 8'd1;
            FILL_INC2:   n_fill = r_fill + 8'd2;
            FILL_RELOAD: n_fill = r_start;
            default:     n_fill = r_fill;
        endcase
    end

    always_comb begin
        unique case (i_cmd.emit_sel)
            SEL_BYTE: begin
                emit_byte = cur_byte;
                emit_last = o_status.last_byte;
            end
            SEL_ESC: begin
                emit_byte = r_escape;
                emit_last = 1'b0;
            end
            SEL_XOR: begin
                emit_byte = cur_byte ^ r_escape;
                emit_last = o_status.last_byte;
            end
            SEL_RAW: begin
                emit_byte = cur_byte;
                emit_last = 1'b1;
            end
            SEL_CR: begin
                emit_byte = CR_BYTE;
                emit_last = 1'b1;
            end
            default: begin
                emit_byte = 8'd0;
                emit_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape    <= ESCAPE_RESET;
            r_cap       <= CAPACITY_RESET;
            r_start     <= START_FILL_RESET;
            r_fill      <= START_FILL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ESCAPE:     r_escape <= i_cfg_data;
                    REG_CAPACITY:   r_cap    <= i_cfg_data;
                    REG_START_FILL: r_start  <= i_cfg_data;
                    default:        r_escape <= r_escape;
                endcase
            end
            r_fill <= n_fill;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_val  <= i_value[VW-1:0];
            r_left <= len_cap;
            r_ovf  <= ovf_in;
        end else if (i_cmd.shift) begin
            r_val  <= r_val >> 8;
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.emit) begin
            r_out_byte <= emit_byte;
            r_out_bv   <= (i_cmd.emit_sel != SEL_NULL);
            r_out_ovf  <= r_ovf || (i_cmd.emit_sel == SEL_NULL);
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_overflow   = r_out_ovf;
    assign o_last       = r_out_last;

endmodule

// File: design/efe_ctrl.sv
module efe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  efe_pkg::t_dp_status  i_status,
    output logic                 o_in_stall,
    output efe_pkg::t_dp_cmd     o_cmd
);
    import efe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_PAIR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.emit_sel = SEL_NULL;
        o_cmd.fill_op  = FILL_HOLD;
        o_cmd.shift    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WORK;
                end
            end
            S_WORK: begin
                unique case (i_status.cmd)
                    CMD_FIELD: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            priority if (!i_status.fits_esc) begin
                                o_cmd.emit_sel = SEL_NULL;
                                n_state        = S_IDLE;
                            end else if (i_status.is_esc) begin
                                o_cmd.emit_sel = SEL_ESC;
                                n_state        = S_PAIR;
                            end else begin
                                o_cmd.emit_sel = SEL_BYTE;
                                o_cmd.fill_op  = FILL_INC1;
                                if (i_status.last_byte) begin
                                    n_state = S_IDLE;
                                end else begin
                                    o_cmd.shift = 1'b1;
                                end
                            end
                        end
                    end
                    CMD_RAW: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_status.fits_plain) begin
                                o_cmd.emit_sel = SEL_RAW;
                                o_cmd.fill_op  = FILL_INC1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_FINISH: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_status.fits_plain) begin
                                o_cmd.emit_sel = SEL_CR;
                            end
                            o_cmd.fill_op = FILL_RELOAD;
                            n_state       = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_PAIR: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_XOR;
                    o_cmd.fill_op  = FILL_INC2;
                    if (i_status.last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.shift = 1'b1;
                        n_state     = S_WORK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: design/escaped_frame_encoder.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_command, i_value, i_field_bytes_code
// result    out        o_out_valid / i_out_stall  o_out_byte, o_byte_valid, o_overflow, o_last
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Sequence: a request is loaded first, then its results follow one per cycle while the
//   result register is free; an escaped byte yields an escape result and then the byte
//   XOR escape. Raw and finish emit a single result; an unused command emits nothing.
// Reset: synchronous, active low; the config registers return to their reset values, the
//   fill count to the start fill reset value, and the result valid and sequencer clear.
// Stalls: a stalled result holds the sequencer; the next request is taken as soon as the
//   sequencer is idle, even while the last result still waits in the output register.
`include "assert_macros.svh"

module escaped_frame_encoder #(
    parameter int MAX_FIELD_BYTES = efe_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  efe_pkg::t_cfg_index  i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [63:0]          i_value,
    input  logic [1:0]           i_field_bytes_code,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_overflow,
    output logic                 o_last
);
    import efe_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer: load a request, then walk its bytes, emitting one result per free output slot.
    efe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // Datapath: config registers, fill count, byte shifter, escape checks and
    // the result register.
    efe_datapath #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_value            (i_value),
        .i_field_bytes_code (i_field_bytes_code),
        .i_out_stall        (i_out_stall),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .o_out_valid        (o_out_valid),
        .o_out_byte         (o_out_byte),
        .o_byte_valid       (o_byte_valid),
        .o_overflow         (o_overflow),
        .o_last             (o_last)
    );

    // An empty result is always flagged and is the final result of its request.
    `ASSERT_IMPLY(a_null_flags, i_clk, i_rst_n, o_out_valid && !o_byte_valid, o_overflow && o_last)
    // An empty result carries a zero byte.
    `ASSERT_IMPLY(a_null_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid, o_out_byte == 8'd0)
    // Only the final result of a request may be empty.
    `ASSERT_IMPLY(a_mid_carries_byte, i_clk, i_rst_n, o_out_valid && !o_last, o_byte_valid)
    // Hold off the next request while one is in flight.
    `ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule
